>>> hw/rtl/kbp_pkg.sv
// shared widths, limits and status codes for the bottleneck path block
`default_nettype none
package kbp_pkg;
  localparam int unsigned NodeFw   = 9;
  localparam int unsigned WeightW  = 31;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned RankW    = 4;
  localparam int unsigned EdgeW    = 2 * NodeFw + WeightW;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 40;

  localparam logic [RankW-1:0] RankMax = 4'd15;

  localparam logic [StatusW-1:0] StOk       = 2'd0;
  localparam logic [StatusW-1:0] StNoPath   = 2'd1;
  localparam logic [StatusW-1:0] StOverflow = 2'd2;
endpackage
`default_nettype wire

>>> hw/rtl/kbp_ram.sv
// generic one-write one-read memory with registered read data
`default_nettype none
module kbp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                            wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                            rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> hw/rtl/kruskal_bottleneck_path.sv
// Minimum bottleneck path between node 1 and node node_count, Kruskal order
// over a union-find memory.
// Input stream s_axis: one edge per item; tlast marks the final edge of a
// graph. Edges load at one item per cycle into the edge memory. The final
// item starts the search and tready stays low until its result is registered.
// Output stream m_axis: one result per graph, held until taken; a stalled
// receiver only delays the block once the next graph's result is ready.
// Config channel cfg: writes node_count, accepted every cycle, use when idle.
// Search steps: a start state and one set-up write per node, then per edge
// taken in weight order a full scan of the stored edges and an endpoint
// check, plus a read and a compare per node visited on up to four root
// walks and up to two writes; the single read port of the node memory
// and the scan set the search time.
// A store overflow answers status 2 from the start state, without a search.
// Reset empties the edge store and sets node_count to 2; the memories are
// not cleared.
`default_nettype none
module kruskal_bottleneck_path
  import kbp_pkg::*;
#(
  parameter int unsigned MAX_EDGES = 1024,
  parameter int unsigned MAX_NODES = 256
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // edge_from [8:0], edge_to [17:9], edge_weight [48:18], zero fill
  input  wire logic [InDataW-1:0]    s_axis_tdata,
  input  wire logic                  s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // bottleneck_weight [30:0], status [32:31], zero fill
  output logic      [OutDataW-1:0]   m_axis_tdata,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [NodeFw-1:0]     cfg_data_i
);
  localparam int unsigned EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned CW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned NW  = $clog2(MAX_NODES);
  localparam int unsigned NCW = $clog2(MAX_NODES + 1);
  localparam int unsigned UW  = RankW + NW;

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_INIT   = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_EDGE   = 4'd4;
  localparam logic [3:0] S_FIND   = 4'd5;
  localparam logic [3:0] S_FCHK   = 4'd6;
  localparam logic [3:0] S_UNI1   = 4'd7;
  localparam logic [3:0] S_UNI2   = 4'd8;
  localparam logic [3:0] S_RESULT = 4'd9;

  localparam logic [1:0] F_A = 2'd0;
  localparam logic [1:0] F_B = 2'd1;
  localparam logic [1:0] F_Z = 2'd2;
  localparam logic [1:0] F_T = 2'd3;

  logic [3:0]          state_q;
  logic [CW-1:0]       cnt_q, j_q;
  logic                ovf_q, rdv_q, hp_q, bf_q, ov_q;
  logic [NodeFw-1:0]   nc_q;
  logic [NCW-1:0]      i_q, n_eff;
  logic [EW-1:0]       rdi_q, pi_q, bi_q;
  logic [WeightW-1:0]  pw_q, bw_q, res_w_q;
  logic [2*NodeFw-1:0] be_q;
  logic [StatusW-1:0]  res_st_q;
  logic [NW-1:0]       cur_q, ra_q, rb_q, r0_q, a_idx, b_idx, t_idx, rd_par;
  logic [RankW-1:0]    rka_q, rkb_q, rd_rank;
  logic [1:0]          sel_q;
  logic [OutDataW-1:0] out_q;

  logic                acc, ewe, nwe, a_ok, b_ok, cand, res_go;
  logic [EdgeW-1:0]    erd;
  logic [UW-1:0]       nrd, nwd;
  logic [NW-1:0]       nwa;
  logic [NodeFw-1:0]   ea, eb;
  logic [WeightW-1:0]  rw;

  assign s_axis_tready = (state_q == S_LOAD);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign ewe           = acc && (cnt_q < CW'(MAX_EDGES));
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = out_q;
  assign res_go        = (state_q == S_RESULT) && (!ov_q || m_axis_tready);

  always_comb begin
    if (int'(nc_q) < 2) begin
      n_eff = NCW'(2);
    end else if (int'(nc_q) > int'(MAX_NODES)) begin
      n_eff = NCW'(MAX_NODES);
    end else begin
      n_eff = NCW'(nc_q);
    end
  end

  assign ea    = be_q[NodeFw-1:0];
  assign eb    = be_q[2*NodeFw-1:NodeFw];
  assign a_ok  = (ea != '0) && (int'(ea) <= int'(n_eff));
  assign b_ok  = (eb != '0) && (int'(eb) <= int'(n_eff));
  assign a_idx = NW'(int'(ea) - 1);
  assign b_idx = NW'(int'(eb) - 1);
  assign t_idx = NW'(int'(n_eff) - 1);

  assign rw      = erd[EdgeW-1:2*NodeFw];
  assign rd_par  = nrd[NW-1:0];
  assign rd_rank = nrd[UW-1:NW];

  // scanned edge is the next in (weight, arrival) order so far
  assign cand = (!hp_q || (rw > pw_q) || ((rw == pw_q) && (rdi_q > pi_q)))
                && (!bf_q || (rw < bw_q));

  kbp_ram #(.Width(EdgeW), .Depth(MAX_EDGES)) u_edges (
    .clk_i   (clk_i),
    .we_i    (ewe),
    .waddr_i (cnt_q[EW-1:0]),
    .wdata_i (s_axis_tdata[EdgeW-1:0]),
    .raddr_i (j_q[EW-1:0]),
    .rdata_o (erd)
  );

  always_comb begin
    nwe = 1'b0;
    nwa = i_q[NW-1:0];
    nwd = {{RankW{1'b0}}, i_q[NW-1:0]};
    case (state_q)
      S_INIT: nwe = 1'b1;
      S_UNI1: begin
        nwe = 1'b1;
        if (rka_q < rkb_q) begin
          nwa = ra_q;
          nwd = {rka_q, rb_q};
        end else begin
          nwa = rb_q;
          nwd = {rkb_q, ra_q};
        end
      end
      S_UNI2: begin
        nwe = 1'b1;
        nwa = ra_q;
        nwd = {rka_q + RankW'(1), ra_q};
      end
      default: nwe = 1'b0;
    endcase
  end

  kbp_ram #(.Width(UW), .Depth(MAX_NODES)) u_sets (
    .clk_i   (clk_i),
    .we_i    (nwe),
    .waddr_i (nwa),
    .wdata_i (nwd),
    .raddr_i (cur_q),
    .rdata_o (nrd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      nc_q     <= NodeFw'(2);
      ov_q     <= 1'b0;
      rdv_q    <= 1'b0;
      hp_q     <= 1'b0;
      bf_q     <= 1'b0;
      j_q      <= '0;
      i_q      <= '0;
      sel_q    <= F_A;
      res_st_q <= StOk;
    end else begin
      if (cfg_valid_i) begin
        nc_q <= cfg_data_i;
      end
      if (res_go) begin
        ov_q <= 1'b1;
      end else if (ov_q && m_axis_tready) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_LOAD: begin
          if (acc) begin
            if (ewe) begin
              cnt_q <= cnt_q + CW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (s_axis_tlast) begin
              state_q <= S_START;
            end
          end
        end
        S_START: begin
          i_q <= '0;
          if (ovf_q) begin
            res_w_q  <= '0;
            res_st_q <= StOverflow;
            state_q  <= S_RESULT;
          end else begin
            state_q <= S_INIT;
          end
        end
        S_INIT: begin
          i_q <= i_q + NCW'(1);
          if (i_q == NCW'(n_eff - NCW'(1))) begin
            hp_q    <= 1'b0;
            bf_q    <= 1'b0;
            j_q     <= '0;
            rdv_q   <= 1'b0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          rdv_q <= (j_q < cnt_q);
          rdi_q <= j_q[EW-1:0];
          if (j_q < cnt_q) begin
            j_q <= j_q + CW'(1);
          end
          if (rdv_q && cand) begin
            bf_q <= 1'b1;
            bw_q <= rw;
            bi_q <= rdi_q;
            be_q <= erd[2*NodeFw-1:0];
          end
          if (!(j_q < cnt_q) && !rdv_q) begin
            if (bf_q) begin
              state_q <= S_EDGE;
            end else begin
              res_w_q  <= '0;
              res_st_q <= StNoPath;
              state_q  <= S_RESULT;
            end
          end
        end
        S_EDGE: begin
          if (a_ok && b_ok) begin
            cur_q   <= a_idx;
            sel_q   <= F_A;
            state_q <= S_FIND;
          end else begin
            hp_q    <= 1'b1;
            pw_q    <= bw_q;
            pi_q    <= bi_q;
            bf_q    <= 1'b0;
            j_q     <= '0;
            state_q <= S_SCAN;
          end
        end
        S_FIND: state_q <= S_FCHK;
        S_FCHK: begin
          if (rd_par != cur_q) begin
            cur_q   <= rd_par;
            state_q <= S_FIND;
          end else begin
            case (sel_q)
              F_A: begin
                ra_q    <= cur_q;
                rka_q   <= rd_rank;
                cur_q   <= b_idx;
                sel_q   <= F_B;
                state_q <= S_FIND;
              end
              F_B: begin
                rb_q  <= cur_q;
                rkb_q <= rd_rank;
                if (ra_q == cur_q) begin
                  hp_q    <= 1'b1;
                  pw_q    <= bw_q;
                  pi_q    <= bi_q;
                  bf_q    <= 1'b0;
                  j_q     <= '0;
                  state_q <= S_SCAN;
                end else begin
                  state_q <= S_UNI1;
                end
              end
              F_Z: begin
                r0_q    <= cur_q;
                cur_q   <= t_idx;
                sel_q   <= F_T;
                state_q <= S_FIND;
              end
              default: begin
                if (r0_q == cur_q) begin
                  res_w_q  <= bw_q;
                  res_st_q <= StOk;
                  state_q  <= S_RESULT;
                end else begin
                  hp_q    <= 1'b1;
                  pw_q    <= bw_q;
                  pi_q    <= bi_q;
                  bf_q    <= 1'b0;
                  j_q     <= '0;
                  state_q <= S_SCAN;
                end
              end
            endcase
          end
        end
        S_UNI1: begin
          if (!(rka_q < rkb_q) && (rka_q == rkb_q) && (rka_q != RankMax)) begin
            state_q <= S_UNI2;
          end else begin
            cur_q   <= '0;
            sel_q   <= F_Z;
            state_q <= S_FIND;
          end
        end
        S_UNI2: begin
          cur_q   <= '0;
          sel_q   <= F_Z;
          state_q <= S_FIND;
        end
        S_RESULT: begin
          // wait for the previous result to leave
          if (res_go) begin
            out_q   <= OutDataW'({res_st_q, res_w_q});
            cnt_q   <= '0;
            ovf_q   <= 1'b0;
            state_q <= S_LOAD;
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire
